// ===== hw/rtl/bwil_pkg.sv =====
// ----------------------------------------------------------------------------
// bwil_pkg
// Shared types for the inverse BWT LF-walk decoder.
// ----------------------------------------------------------------------------
package bwil_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_ERR,
    ST_SUM,
    ST_W_HEAD,
    ST_W_LF,
    ST_W_ROW,
    ST_W_EMIT
  } bwil_state_t;

endpackage

// ===== hw/rtl/bwil_ram.sv =====
// ----------------------------------------------------------------------------
// bwil_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bwil_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bwil_ctrl.sv =====
// ----------------------------------------------------------------------------
// bwil_ctrl
// Load, prefix-sum sweep, LF walk and output register of the decoder.
// ----------------------------------------------------------------------------
module bwil_ctrl #(
  parameter int BLOCK_SIZE = 64,
  parameter int ALPHABET   = 257,
  localparam int SYM_W = $clog2(ALPHABET),
  localparam int ROW_W = $clog2(BLOCK_SIZE),
  localparam int CNT_W = $clog2(BLOCK_SIZE + 1),
  localparam int CR_W  = ROW_W + SYM_W,
  localparam int CT_W  = 2 * CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_sym,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_sym,
  output logic [ROW_W-1:0] out_pos,
  output logic             out_last,
  output logic             out_err,
  output logic             cr_we,
  output logic [ROW_W-1:0] cr_waddr,
  output logic [CR_W-1:0]  cr_wdata,
  output logic             cr_re,
  output logic [ROW_W-1:0] cr_raddr,
  input  logic [CR_W-1:0]  cr_rdata,
  output logic             cnt_we,
  output logic [SYM_W-1:0] cnt_waddr,
  output logic [CT_W-1:0]  cnt_wdata,
  output logic             cnt_re,
  output logic [SYM_W-1:0] cnt_raddr,
  input  logic [CT_W-1:0]  cnt_rdata
);

  localparam int IDX_W = $clog2(ALPHABET + 1);
  localparam logic [IDX_W-1:0] ALPHA_N  = IDX_W'(ALPHABET);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET - 1);
  localparam logic [SYM_W-1:0] EOB      = SYM_W'(ALPHABET - 1);
  localparam logic [CNT_W-1:0] BLK_N    = CNT_W'(BLOCK_SIZE);

  bwil_pkg::bwil_state_t state_r, state_nxt;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [ROW_W-1:0] end_row_r, end_row_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] sum_r, sum_nxt;
  logic [ROW_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic [ROW_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_err_r, out_err_nxt;

  logic             in_ok, ld_ok, ld_err, slot_free;
  logic [SYM_W-1:0] cr_sym;
  logic [ROW_W-1:0] cr_rank;
  logic [CNT_W-1:0] cnt_count, cnt_start, row_sum;
  logic [IDX_W-1:0] idx_m1;

  assign cr_sym    = cr_rdata[SYM_W-1:0];
  assign cr_rank   = cr_rdata[CR_W-1:SYM_W];
  assign cnt_count = cnt_rdata[CNT_W-1:0];
  assign cnt_start = cnt_rdata[CT_W-1:CNT_W];
  assign row_sum   = CNT_W'(cr_rank) + cnt_start;
  assign idx_m1    = idx_r - IDX_W'(1);

  assign in_ok  = (IDX_W'(in_sym) < ALPHA_N) && (fill_r < BLK_N);
  assign ld_ok  = (IDX_W'(sym_r) < ALPHA_N) && (fill_r < BLK_N);
  assign ld_err = ovf_r || !ld_ok || !(end_seen_r || (sym_r == EOB));
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwil_pkg::ST_CLEAR: begin
        if (idx_r == LAST_IDX) state_nxt = bwil_pkg::ST_IDLE;
      end
      bwil_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = bwil_pkg::ST_LOAD;
      end
      bwil_pkg::ST_LOAD: begin
        if (!last_r) begin
          state_nxt = bwil_pkg::ST_IDLE;
        end else if (ld_err) begin
          state_nxt = bwil_pkg::ST_ERR;
        end else begin
          state_nxt = bwil_pkg::ST_SUM;
        end
      end
      bwil_pkg::ST_ERR: begin
        if (slot_free) state_nxt = bwil_pkg::ST_CLEAR;
      end
      bwil_pkg::ST_SUM: begin
        if (idx_r == ALPHA_N) state_nxt = bwil_pkg::ST_W_HEAD;
      end
      bwil_pkg::ST_W_HEAD: begin
        if (fill_r == CNT_W'(1)) begin
          state_nxt = bwil_pkg::ST_IDLE;
        end else begin
          state_nxt = bwil_pkg::ST_W_LF;
        end
      end
      bwil_pkg::ST_W_LF: begin
        state_nxt = bwil_pkg::ST_W_ROW;
      end
      bwil_pkg::ST_W_ROW: begin
        state_nxt = bwil_pkg::ST_W_EMIT;
      end
      bwil_pkg::ST_W_EMIT: begin
        if (slot_free) begin
          if (pos_r == '0) begin
            state_nxt = bwil_pkg::ST_IDLE;
          end else begin
            state_nxt = bwil_pkg::ST_W_LF;
          end
        end
      end
      default: state_nxt = bwil_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready      = 1'b0;
    cr_we         = 1'b0;
    cr_waddr      = fill_r[ROW_W-1:0];
    cr_wdata      = {ROW_W'(cnt_count), sym_r};
    cr_re         = 1'b0;
    cr_raddr      = end_row_r;
    cnt_we        = 1'b0;
    cnt_waddr     = sym_r;
    cnt_wdata     = {cnt_start, cnt_count + CNT_W'(1)};
    cnt_re        = 1'b0;
    cnt_raddr     = in_sym;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    end_row_nxt   = end_row_r;
    end_seen_nxt  = end_seen_r;
    ovf_nxt       = ovf_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sym_nxt   = out_sym_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    unique case (state_r)
      bwil_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_r[SYM_W-1:0];
        cnt_wdata = '0;
        idx_nxt   = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
      end
      bwil_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sym_nxt  = in_sym;
          last_nxt = in_last;
          cnt_re   = in_ok;
        end
      end
      bwil_pkg::ST_LOAD: begin
        // count read issued on the accept cycle; write back here
        if (ld_ok) begin
          cr_we    = 1'b1;
          cnt_we   = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
          if (sym_r == EOB) begin
            end_row_nxt  = fill_r[ROW_W-1:0];
            end_seen_nxt = 1'b1;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
        idx_nxt = '0;
        sum_nxt = '0;
      end
      bwil_pkg::ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = '0;
          out_pos_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          fill_nxt      = '0;
          end_row_nxt   = '0;
          end_seen_nxt  = 1'b0;
          ovf_nxt       = 1'b0;
          idx_nxt       = '0;
        end
      end
      bwil_pkg::ST_SUM: begin
        // read entry idx while entry idx-1 gets its start and a zero count
        cnt_re    = (idx_r < ALPHA_N);
        cnt_raddr = idx_r[SYM_W-1:0];
        if (idx_r != '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = idx_m1[SYM_W-1:0];
          cnt_wdata = {sum_r, CNT_W'(0)};
          sum_nxt   = sum_r + cnt_count;
        end
        idx_nxt = idx_r + IDX_W'(1);
      end
      bwil_pkg::ST_W_HEAD: begin
        cr_re        = 1'b1;
        cr_raddr     = end_row_r;
        pos_nxt      = ROW_W'(fill_r - CNT_W'(2));
        fill_nxt     = '0;
        end_row_nxt  = '0;
        end_seen_nxt = 1'b0;
        ovf_nxt      = 1'b0;
      end
      bwil_pkg::ST_W_LF: begin
        cnt_re    = 1'b1;
        cnt_raddr = cr_sym;
      end
      bwil_pkg::ST_W_ROW: begin
        cr_re    = 1'b1;
        cr_raddr = row_sum[ROW_W-1:0];
      end
      bwil_pkg::ST_W_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = cr_sym;
          out_pos_nxt   = pos_r;
          out_last_nxt  = (pos_r == '0);
          out_err_nxt   = 1'b0;
          pos_nxt       = pos_r - ROW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bwil_pkg::ST_CLEAR;
      idx_r       <= '0;
      fill_r      <= '0;
      end_row_r   <= '0;
      end_seen_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      end_row_r   <= end_row_nxt;
      end_seen_r  <= end_seen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    sum_r      <= sum_nxt;
    pos_r      <= pos_nxt;
    out_sym_r  <= out_sym_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sym   = out_sym_r;
  assign out_pos   = out_pos_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

endmodule

// ===== hw/rtl/bwt_inverse_lf_walk_top.sv =====
// ----------------------------------------------------------------------------
// bwt_inverse_lf_walk_top
// Inverse BWT decoder: loads a last column, then walks the LF mapping.
// ----------------------------------------------------------------------------
// Load: per input transfer a count RAM read, then its write back, before
//   the next transfer is accepted. On tlast: prefix sweep over the count RAM,
//   head read, then per decoded symbol a count RAM read, a column RAM read
//   and the output register, which waits while the previous result is not taken.
// Error block: one result, then a clear of all ALPHABET count RAM entries.
// Reset: synchronous; a clear of the count RAM runs before in_tready.
module bwt_inverse_lf_walk_top #(
  parameter int BLOCK_SIZE = 64,
  parameter int ALPHABET   = 257,
  localparam int SYM_W  = $clog2(ALPHABET),
  localparam int ROW_W  = $clog2(BLOCK_SIZE),
  localparam int IN_TW  = ((SYM_W + 7) / 8) * 8,
  localparam int OUT_TW = ((SYM_W + ROW_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // sym
  input  logic              in_tlast,   // block_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // decoded, position
  output logic              out_tlast,  // final_res
  output logic              out_tuser   // error
);

  localparam int CNT_W = $clog2(BLOCK_SIZE + 1);
  localparam int CR_W  = ROW_W + SYM_W;
  localparam int CT_W  = 2 * CNT_W;

  logic             cr_we, cr_re, cnt_we, cnt_re;
  logic [ROW_W-1:0] cr_waddr, cr_raddr;
  logic [CR_W-1:0]  cr_wdata, cr_rdata;
  logic [SYM_W-1:0] cnt_waddr, cnt_raddr;
  logic [CT_W-1:0]  cnt_wdata, cnt_rdata;
  logic [SYM_W-1:0] out_sym;
  logic [ROW_W-1:0] out_pos;

  bwil_ram #(.WIDTH(CR_W), .DEPTH(BLOCK_SIZE)) u_col_ram (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_waddr),
    .wdata (cr_wdata),
    .re    (cr_re),
    .raddr (cr_raddr),
    .rdata (cr_rdata)
  );

  bwil_ram #(.WIDTH(CT_W), .DEPTH(ALPHABET)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  bwil_ctrl #(.BLOCK_SIZE(BLOCK_SIZE), .ALPHABET(ALPHABET)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sym    (in_tdata[SYM_W-1:0]),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sym   (out_sym),
    .out_pos   (out_pos),
    .out_last  (out_tlast),
    .out_err   (out_tuser),
    .cr_we     (cr_we),
    .cr_waddr  (cr_waddr),
    .cr_wdata  (cr_wdata),
    .cr_re     (cr_re),
    .cr_raddr  (cr_raddr),
    .cr_rdata  (cr_rdata),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_re    (cnt_re),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata)
  );

  assign out_tdata = OUT_TW'({out_pos, out_sym});

  a_rmw_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while count write-back pending");

  a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error result not marked final");

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0))
    else $error("error result carries data");

  a_final_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser |-> (out_pos == '0))
    else $error("final decoded symbol not at position zero");

endmodule
